FILE: src/sqct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqct_pkg
// Shared constants, types and the quarter-wave sine table for the sprite
// quad corner transform.
// ----------------------------------------------------------------------------
package sqct_pkg;

	localparam int TRIG_DEPTH = 1024;
	localparam int IDX_W      = $clog2(TRIG_DEPTH);
	localparam int QTR        = TRIG_DEPTH / 4;
	localparam int QTR_W      = $clog2(QTR);

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	// field widths of the datapath
	localparam int ANG_W  = 16;
	localparam int TRIG_W = 16;
	localparam int PROD_W = 30;
	localparam int TERM_W = 46;
	localparam int CEN_W  = 47;
	localparam int ACC_W  = 64;
	localparam int OUT_W  = 32;

	localparam logic [1:0] LAST_IDX = 2'd3;

	typedef logic [14:0] qsin_tab_t [QTR+1];

	typedef struct packed {
		logic signed [ACC_W-1:0]  a;
		logic signed [ACC_W-1:0]  b;
		logic signed [TERM_W-1:0] x11;
		logic signed [TERM_W-1:0] x21;
		logic signed [TERM_W-1:0] y12;
		logic signed [TERM_W-1:0] y22;
	} basis_t;

	typedef struct packed {
		logic [1:0]              idx;
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic                    last;
	} corner_t;

	// sine of a first-quadrant phase in Q30, series to x^15, rounded to Q1.14
	function automatic logic [14:0] sin_q14(longint unsigned r);
		longint unsigned theta;
		longint unsigned x2;
		longint unsigned term;
		longint          s;
		theta = (r * PI_HALF_Q30) >> 30;
		x2    = (theta * theta) >> 30;
		term  = theta;
		s     = longint'(theta);
		term  = ((term * x2) >> 30) / 6;   s = s - longint'(term);
		term  = ((term * x2) >> 30) / 20;  s = s + longint'(term);
		term  = ((term * x2) >> 30) / 42;  s = s - longint'(term);
		term  = ((term * x2) >> 30) / 72;  s = s + longint'(term);
		term  = ((term * x2) >> 30) / 110; s = s - longint'(term);
		term  = ((term * x2) >> 30) / 156; s = s + longint'(term);
		term  = ((term * x2) >> 30) / 210; s = s - longint'(term);
		if (s < 0)
			s = 0;
		s = (s + 32768) >>> 16;
		if (s > 16384)
			s = 16384;
		return 15'(s);
	endfunction

	function automatic qsin_tab_t build_qsin_tab();
		qsin_tab_t t;
		for (int i = 0; i <= QTR; i++)
			t[i] = sin_q14(longint'(i) << (30 - QTR_W));
		return t;
	endfunction

	localparam qsin_tab_t QSIN_TAB = build_qsin_tab();

	// table sine or cosine of a 16-bit turn fraction, Q1.14
	function automatic logic signed [TRIG_W-1:0] trig_q14(logic [ANG_W-1:0] angle,
			logic cos_sel);
		logic [IDX_W-1:0]         i;
		logic [1:0]               quad;
		logic [QTR_W:0]           r;
		logic [QTR_W:0]           f;
		logic signed [TRIG_W-1:0] mag;
		i    = angle[ANG_W-1 -: IDX_W] + (cos_sel ? IDX_W'(QTR) : '0);
		quad = i[IDX_W-1 -: 2];
		r    = {1'b0, i[QTR_W-1:0]};
		f    = quad[0] ? (QTR_W+1)'(QTR) - r : r;
		mag  = {1'b0, QSIN_TAB[f]};
		return quad[1] ? -mag : mag;
	endfunction

endpackage

FILE: src/sqct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqct_if
// Valid/ready channels: sprite descriptors in, transformed corners out.
// ----------------------------------------------------------------------------
interface sqct_sprite_if;
	logic               valid;
	logic               ready;
	logic        [15:0] angle_x;
	logic        [15:0] angle_y;
	logic        [15:0] angle_z;
	logic signed [15:0] scale_x;
	logic signed [15:0] scale_y;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic signed [31:0] move_x;
	logic signed [31:0] move_y;

	modport source(output valid, angle_x, angle_y, angle_z, scale_x, scale_y,
		center_x, center_y, move_x, move_y, input ready);
	modport sink(input valid, angle_x, angle_y, angle_z, scale_x, scale_y,
		center_x, center_y, move_x, move_y, output ready);
endinterface

interface sqct_corner_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  corner_index;
	logic signed [31:0] corner_x;
	logic signed [31:0] corner_y;
	logic               last_corner;

	modport source(output valid, corner_index, corner_x, corner_y, last_corner,
		input ready);
	modport sink(input valid, corner_index, corner_x, corner_y, last_corner,
		output ready);
endinterface

FILE: src/sqct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqct_front
// Four-stage pipeline: trig lookup, cosine products, basis and center terms,
// moved center. Produces the basis that the corner cells expand.
// ----------------------------------------------------------------------------
module sqct_front (
	input  logic               clk,
	input  logic               arst_n,
	sqct_sprite_if.sink        sprite,
	input  logic               take,
	output logic               basis_valid,
	output sqct_pkg::basis_t   basis
);
	import sqct_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [TRIG_W-1:0] cx_s1, cy_s1, sz_s1, cz_s1;
	logic signed [15:0]       scx_s1, scy_s1, cenx_s1, ceny_s1;
	logic signed [31:0]       mvx_s1, mvy_s1;

	logic signed [PROD_W-1:0] xc_s2, xs_s2, ys_s2, yc_s2;
	logic signed [15:0]       scx_s2, scy_s2, cenx_s2, ceny_s2;
	logic signed [31:0]       mvx_s2, mvy_s2;

	logic signed [TERM_W-1:0] x11_s3, x21_s3, y12_s3, y22_s3;
	logic signed [CEN_W-1:0]  pa_s3, pb_s3;
	logic signed [15:0]       scx_s3, scy_s3;
	logic signed [31:0]       mvx_s3, mvy_s3;

	basis_t basis_s4;

	// whole pipeline stalls together while the cell row is still busy
	assign en           = !v_s4 || take;
	assign sprite.ready = en;
	assign basis_valid  = v_s4;
	assign basis        = basis_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sprite.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1   <= trig_q14(sprite.angle_x, 1'b1);
			cy_s1   <= trig_q14(sprite.angle_y, 1'b1);
			sz_s1   <= trig_q14(sprite.angle_z, 1'b0);
			cz_s1   <= trig_q14(sprite.angle_z, 1'b1);
			scx_s1  <= sprite.scale_x;
			scy_s1  <= sprite.scale_y;
			cenx_s1 <= sprite.center_x;
			ceny_s1 <= sprite.center_y;
			mvx_s1  <= sprite.move_x;
			mvy_s1  <= sprite.move_y;

			xc_s2   <= PROD_W'(cx_s1) * PROD_W'(cz_s1);
			xs_s2   <= PROD_W'(cx_s1) * PROD_W'(sz_s1);
			ys_s2   <= -(PROD_W'(cy_s1) * PROD_W'(sz_s1));
			yc_s2   <= PROD_W'(cy_s1) * PROD_W'(cz_s1);
			scx_s2  <= scx_s1;
			scy_s2  <= scy_s1;
			cenx_s2 <= cenx_s1;
			ceny_s2 <= ceny_s1;
			mvx_s2  <= mvx_s1;
			mvy_s2  <= mvy_s1;

			x11_s3 <= TERM_W'(xc_s2) * TERM_W'(scx_s2);
			x21_s3 <= TERM_W'(xs_s2) * TERM_W'(scx_s2);
			y12_s3 <= TERM_W'(ys_s2) * TERM_W'(scy_s2);
			y22_s3 <= TERM_W'(yc_s2) * TERM_W'(scy_s2);
			pa_s3  <= CEN_W'(TERM_W'(cenx_s2) * TERM_W'(xc_s2))
				+ CEN_W'(TERM_W'(ceny_s2) * TERM_W'(xs_s2));
			pb_s3  <= CEN_W'(TERM_W'(cenx_s2) * TERM_W'(ys_s2))
				+ CEN_W'(TERM_W'(ceny_s2) * TERM_W'(yc_s2));
			scx_s3 <= scx_s2;
			scy_s3 <= scy_s2;
			mvx_s3 <= mvx_s2;
			mvy_s3 <= mvy_s2;

			basis_s4.a   <= ACC_W'(pa_s3) * ACC_W'(scx_s3) + (ACC_W'(mvx_s3) <<< 28);
			basis_s4.b   <= ACC_W'(pb_s3) * ACC_W'(scy_s3) + (ACC_W'(mvy_s3) <<< 28);
			basis_s4.x11 <= x11_s3;
			basis_s4.x21 <= x21_s3;
			basis_s4.y12 <= y12_s3;
			basis_s4.y22 <= y22_s3;
		end
	end

endmodule

FILE: src/sqct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqct_cell
// One corner slot of the output row. On load it forms its own corner from
// the basis; on shift it takes the corner of its upstream neighbor.
// ----------------------------------------------------------------------------
module sqct_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         idx,
	input  logic               load,
	input  logic               shift,
	input  sqct_pkg::basis_t   basis,
	input  logic               nb_valid,
	input  sqct_pkg::corner_t  nb_corner,
	output logic               valid,
	output sqct_pkg::corner_t  corner
);
	import sqct_pkg::*;

	logic              valid_q;
	corner_t           corner_q;
	corner_t           own;
	logic signed [ACC_W-1:0] sx, sy;

	// Q44 to Q16.16, round half up, clamp
	function automatic logic signed [OUT_W-1:0] to_out(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] f;
		t = v + (ACC_W'(1) <<< 27);
		f = t >>> 28;
		if (f > ACC_W'(64'sd2147483647))
			return {1'b0, {(OUT_W-1){1'b1}}};
		else if (f < -ACC_W'(64'sd2147483648))
			return {1'b1, {(OUT_W-1){1'b0}}};
		else
			return f[OUT_W-1:0];
	endfunction

	// corner sign pattern: x11/y12 positive on odd corners, x21/y22 on top row
	always_comb begin
		sx = basis.a
			+ (idx[0] ? (ACC_W'(basis.x11) <<< 8) : -(ACC_W'(basis.x11) <<< 8))
			+ (idx[1] ? -(ACC_W'(basis.x21) <<< 8) : (ACC_W'(basis.x21) <<< 8));
		sy = basis.b
			+ (idx[0] ? (ACC_W'(basis.y12) <<< 8) : -(ACC_W'(basis.y12) <<< 8))
			+ (idx[1] ? -(ACC_W'(basis.y22) <<< 8) : (ACC_W'(basis.y22) <<< 8));
		own.idx  = idx;
		own.x    = to_out(sx);
		own.y    = to_out(sy);
		own.last = (idx == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (shift)
			valid_q <= nb_valid;
	end

	always_ff @(posedge clk) begin
		if (load)
			corner_q <= own;
		else if (shift)
			corner_q <= nb_corner;
	end

	assign valid  = valid_q;
	assign corner = corner_q;

endmodule

FILE: src/sprite_quad_corner_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_corner_transform_core
// Turns one sprite descriptor into the four transformed corners of its quad.
// ----------------------------------------------------------------------------
// Usage:
//   sprite : valid/ready sink, one sprite descriptor per transfer.
//   corner : valid/ready source, four transfers per sprite in corner order
//            0..3, last_corner set on corner 3.
//   The sprite transfer fills stage one; the basis then passes stages two
//   to four and is loaded from stage four into the corner row, where the
//   first corner becomes valid.
//   Throughput: one corner per cycle while the receiver is ready, set by the
//   single corner channel draining the four-cell corner row.
//   A new sprite is taken while corners of earlier sprites are still in the
//   pipeline or waiting in the row; the row is reloaded in the same cycle
//   its final corner leaves.
//   When the receiver stalls, the row holds and the front pipeline stops
//   once its last stage is full; sprite.ready then drops.
//   Reset clears all valid flags; no sprite is in flight afterwards.
// ----------------------------------------------------------------------------
module sprite_quad_corner_transform_core (
	input  logic           clk,
	input  logic           arst_n,
	sqct_sprite_if.sink    sprite,
	sqct_corner_if.source  corner
);
	import sqct_pkg::*;

	localparam int NCELL = 4;

	basis_t  basis;
	logic    basis_valid;
	logic    load;
	logic    shift;
	logic    cell_v [NCELL+1];
	corner_t cell_d [NCELL+1];

	sqct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sprite     (sprite),
		.take       (load),
		.basis_valid(basis_valid),
		.basis      (basis)
	);

	assign shift = corner.ready && cell_v[0];
	// row accepts a new sprite when at most the head corner is left and it leaves
	assign load  = basis_valid && !cell_v[1] && (!cell_v[0] || corner.ready);

	assign cell_v[NCELL] = 1'b0;
	assign cell_d[NCELL] = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		sqct_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (2'(k)),
			.load     (load),
			.shift    (shift),
			.basis    (basis),
			.nb_valid (cell_v[k+1]),
			.nb_corner(cell_d[k+1]),
			.valid    (cell_v[k]),
			.corner   (cell_d[k])
		);
	end

	assign corner.valid        = cell_v[0];
	assign corner.corner_index = cell_d[0].idx;
	assign corner.corner_x     = cell_d[0].x;
	assign corner.corner_y     = cell_d[0].y;
	assign corner.last_corner  = cell_d[0].last;

endmodule

FILE: src/sqct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqct_checker
// Port-level checks on the corner channel of the transform core.
// ----------------------------------------------------------------------------
module sqct_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               valid,
	input logic               ready,
	input logic        [1:0]  idx,
	input logic signed [31:0] x,
	input logic signed [31:0] y,
	input logic               last
);
	import sqct_pkg::*;

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last == (idx == LAST_IDX)))
		else $error("last_corner does not match corner 3");

	// once a corner of a sprite leaves, its next corner is valid right away, in index order
	a_next_corner: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && !last |=> valid && (idx == $past(idx) + 2'd1))
		else $error("corner sequence broken inside a sprite");

	a_new_sprite: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && last |=> !valid || (idx == 2'd0))
		else $error("sprite does not start at corner 0");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(idx) && $stable(x) && $stable(y))
		else $error("stalled corner transfer changed");

endmodule

bind sprite_quad_corner_transform_core sqct_checker u_sqct_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.valid (corner.valid),
	.ready (corner.ready),
	.idx   (corner.corner_index),
	.x     (corner.corner_x),
	.y     (corner.corner_y),
	.last  (corner.last_corner)
);
